// ===== src/tournament_hamiltonian_path_count_top_defines.svh =====
// Assertion macros shared by the tournament path counter checker.
`ifndef TOURNAMENT_HAMILTONIAN_PATH_COUNT_TOP_DEFINES_SVH
`define TOURNAMENT_HAMILTONIAN_PATH_COUNT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define THPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define THPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/thpc_pkg.sv =====
// Shared constants, types and the row adder tree of the tournament path counter.
package thpc_pkg;

  localparam int MaxVert   = 11;
  localparam int CountW    = 17;
  localparam int ArcW      = 55;
  localparam int NumW      = 4;
  localparam int MaskW     = MaxVert;
  localparam int RowW      = MaxVert * CountW;
  localparam int TableRows = 1 << MaxVert;
  localparam int SumLeaves = 16;
  localparam int InDataW   = ((ArcW + 7) / 8) * 8;
  localparam int OutDataW  = ((CountW + 7) / 8) * 8;
  localparam logic [NumW-1:0] CfgReset = NumW'(9);

  typedef logic [MaxVert-1:0][CountW-1:0] row_t;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StLoad  = 5'b00010,
    StRun   = 5'b00100,
    StDrain = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  // Sum the selected entries of one row through a balanced adder tree (mod 2^CountW).
  function automatic logic [CountW-1:0] row_sum(row_t row, logic [MaxVert-1:0] sel);
    logic [SumLeaves-1:0][CountW-1:0] lvl;
    int k;
    int s;
    lvl = '0;
    for (k = 0; k < MaxVert; k++) begin
      if (sel[k]) begin
        lvl[k] = row[k];
      end
    end
    for (s = SumLeaves / 2; s > 0; s = s >> 1) begin
      for (k = 0; k < s; k++) begin
        lvl[k] = lvl[2*k] + lvl[2*k+1];
      end
    end
    return lvl[0];
  endfunction

endpackage

// ===== src/thpc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module thpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word; the read word is registered into rdata_q.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tournament_hamiltonian_path_count_top.sv =====
// Top level: Hamiltonian path counter for tournaments, subset-by-endpoint DP over a row memory.
// The single read port of the row memory sets the rate: at most one row read per (subset, endpoint) step.
// A new word is accepted only once the last one is done; a finished count waits in an output register.
// rst_ni (asynchronous, active low) clears the control state and sets vertex_count to 9.
// The row memory needs no clearing pass: every row is written before its value is used.
module tournament_hamiltonian_path_count_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [thpc_pkg::NumW-1:0]         cfg_wdata_i,     // vertex_count
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [thpc_pkg::InDataW-1:0]      s_axis_tdata_i,  // [54:0] arc_orientation
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [thpc_pkg::OutDataW-1:0]     m_axis_tdata_o   // [16:0] path_count
);

  localparam int AddrW = $clog2(thpc_pkg::TableRows);
  localparam int IdxW  = $clog2(thpc_pkg::MaxVert);

  thpc_pkg::state_e state_q, state_d;

  logic [thpc_pkg::NumW-1:0]  cfg_q;
  logic [thpc_pkg::NumW-1:0]  n_q;
  logic                       zero_q;
  logic [thpc_pkg::ArcW-1:0]  arc_q;
  logic [thpc_pkg::MaxVert-1:0][thpc_pkg::MaxVert-1:0] in_q;  // in_q[w][v]: v beats w
  logic [thpc_pkg::NumW-1:0]  pi_q, pj_q;
  logic [thpc_pkg::MaskW-1:0] mask_q;
  logic [thpc_pkg::NumW-1:0]  w_q;
  logic [thpc_pkg::MaskW-1:0] full;
  logic [thpc_pkg::MaskW-1:0] w_bit;
  logic [thpc_pkg::MaskW-1:0] low_sel;
  logic                       in_acc;

  // Read stage registers
  logic                       s1_valid_q;
  logic [IdxW-1:0]            s1_w_q;
  logic [thpc_pkg::MaskW-1:0] s1_raddr_q;
  logic [thpc_pkg::MaskW-1:0] s1_mask_q;
  logic                       s1_last_q;
  logic                       s1_single_q;
  logic                       s1_inset_q;

  // Row assembly and forwarding
  thpc_pkg::row_t             row_q, row_next, rd_row, src_row, fwd_row_q;
  logic [thpc_pkg::MaskW-1:0] fwd_addr_q;
  logic                       fwd_valid_q;
  logic [thpc_pkg::CountW-1:0] entry;
  logic                       mem_we, mem_re;
  logic [thpc_pkg::RowW-1:0]  mem_rdata;

  logic                        m_valid_q;
  logic [thpc_pkg::CountW-1:0] m_data_q;
  logic [thpc_pkg::CountW-1:0] total;

  assign s_axis_tready_o = (state_q == thpc_pkg::StIdle);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign full            = thpc_pkg::MaskW'((12'(1) << n_q) - 12'(1));
  assign low_sel         = full;
  assign w_bit           = thpc_pkg::MaskW'(1) << w_q;
  assign mem_re          = (state_q == thpc_pkg::StRun) && ((mask_q & w_bit) != '0);
  assign mem_we          = s1_valid_q && s1_last_q;
  assign rd_row          = thpc_pkg::row_t'(mem_rdata);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= thpc_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Sequencer: load pairs, walk subsets and endpoints, drain, hand off; zero vertices go straight to hand off
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      thpc_pkg::StIdle: begin
        if (in_acc) begin
          state_d = (cfg_q == '0) ? thpc_pkg::StDone : thpc_pkg::StLoad;
        end
      end
      thpc_pkg::StLoad: begin
        if ((pi_q + 4'd1) >= n_q) begin
          state_d = thpc_pkg::StRun;
        end
      end
      thpc_pkg::StRun: begin
        if ((w_q == n_q - 4'd1) && (mask_q == full)) begin
          state_d = thpc_pkg::StDrain;
        end
      end
      thpc_pkg::StDrain: state_d = thpc_pkg::StDone;
      thpc_pkg::StDone: begin
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = thpc_pkg::StIdle;
        end
      end
      default: state_d = thpc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thpc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the word, build in-neighbor sets one pair a cycle, step the walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_q  <= '0;
      n_q    <= '0;
      zero_q <= 1'b0;
      in_q   <= '0;
      pi_q   <= '0;
      pj_q   <= '0;
      mask_q <= '0;
      w_q    <= '0;
    end else begin
      unique case (state_q)
        thpc_pkg::StIdle: begin
          if (in_acc) begin
            arc_q  <= s_axis_tdata_i[thpc_pkg::ArcW-1:0];
            n_q    <= (cfg_q > thpc_pkg::NumW'(thpc_pkg::MaxVert)) ?
                      thpc_pkg::NumW'(thpc_pkg::MaxVert) : cfg_q;
            zero_q <= (cfg_q == '0);
            in_q   <= '0;
            pi_q   <= '0;
            pj_q   <= 4'd1;
            mask_q <= thpc_pkg::MaskW'(1);
            w_q    <= '0;
          end
        end
        thpc_pkg::StLoad: begin
          if ((pi_q + 4'd1) < n_q) begin
            if (arc_q[0]) begin
              in_q[pj_q[IdxW-1:0]][pi_q[IdxW-1:0]] <= 1'b1;
            end else begin
              in_q[pi_q[IdxW-1:0]][pj_q[IdxW-1:0]] <= 1'b1;
            end
            arc_q <= arc_q >> 1;
            if (pj_q + 4'd1 == n_q) begin
              pi_q <= pi_q + 4'd1;
              pj_q <= pi_q + 4'd2;
            end else begin
              pj_q <= pj_q + 4'd1;
            end
          end
        end
        thpc_pkg::StRun: begin
          if (w_q == n_q - 4'd1) begin
            w_q    <= '0;
            mask_q <= mask_q + thpc_pkg::MaskW'(1);
          end else begin
            w_q <= w_q + 4'd1;
          end
        end
        thpc_pkg::StDrain, thpc_pkg::StDone: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Read stage: remember which entry the returning row feeds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= (state_q == thpc_pkg::StRun);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_w_q      <= w_q[IdxW-1:0];
    s1_raddr_q  <= mask_q ^ w_bit;
    s1_mask_q   <= mask_q;
    s1_last_q   <= (w_q == n_q - 4'd1);
    s1_single_q <= (mask_q == w_bit);
    s1_inset_q  <= ((mask_q & w_bit) != '0);
  end

  // Entry: sum over in-neighbors of the end vertex within the smaller subset (1 if alone, 0 if outside)
  always_comb begin
    src_row  = (fwd_valid_q && (fwd_addr_q == s1_raddr_q)) ? fwd_row_q : rd_row;
    if (!s1_inset_q) begin
      entry = '0;
    end else if (s1_single_q) begin
      entry = thpc_pkg::CountW'(1);
    end else begin
      entry = thpc_pkg::row_sum(src_row, in_q[s1_w_q] & s1_raddr_q);
    end
    row_next         = row_q;
    row_next[s1_w_q] = entry;
  end

  // Assemble the row; keep the last written row for a same-cycle read
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      row_q[s1_w_q] <= entry;
    end
    if (mem_we) begin
      fwd_addr_q <= s1_mask_q;
      fwd_row_q  <= row_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (in_acc) begin
      fwd_valid_q <= 1'b0;
    end else if (mem_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  thpc_ram #(
    .Width (thpc_pkg::RowW),
    .Depth (thpc_pkg::TableRows)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(s1_mask_q)),
    .wdata_i (thpc_pkg::RowW'(row_next)),
    .re_i    (mem_re),
    .raddr_i (AddrW'(mask_q ^ w_bit)),
    .rdata_o (mem_rdata)
  );

  // Output register: total over the full-set row
  assign total = zero_q ? '0 : thpc_pkg::row_sum(row_q, low_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == thpc_pkg::StDone) && (!m_valid_q || m_axis_tready_i)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == thpc_pkg::StDone) && (!m_valid_q || m_axis_tready_i)) begin
      m_data_q <= total;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = thpc_pkg::OutDataW'(m_data_q);

endmodule

// ===== src/thpc_checker.sv =====
// Port-level checker for the tournament path counter, bound to the top level.
`include "tournament_hamiltonian_path_count_top_defines.svh"

module thpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [thpc_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // Hold a stalled result word
  `THPC_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result dropped while stalled")
  `THPC_ASSERT_NXT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o), "result changed while stalled")
  // One word at a time: input closes right after a word is taken
  `THPC_ASSERT_NXT(a_in_close, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input still open after accept")
  // A new result only appears after the input was closed for computation
  `THPC_ASSERT_IMP(a_out_after_work, $rose(m_axis_tvalid_o), !$past(s_axis_tready_o), "result without work")

endmodule

bind tournament_hamiltonian_path_count_top thpc_checker u_thpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/tournament_hamiltonian_path_count_top_tb.sv =====
// Self-checking testbench for the tournament Hamiltonian path counter.
module tournament_hamiltonian_path_count_top_tb;

  localparam int QuietLimit  = 120000;
  localparam int TailCycles  = 100;
  localparam int TableDepth  = 1 << thpc_pkg::MaxVert;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [thpc_pkg::NumW-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [thpc_pkg::InDataW-1:0] s_axis_tdata = '0;  // [54:0] arc_orientation
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [thpc_pkg::OutDataW-1:0] m_axis_tdata;      // [16:0] path_count

  // Model state: the vertex count now in the block and the expected counts in order.
  logic [thpc_pkg::NumW-1:0] vertex_count_setting = thpc_pkg::CfgReset;
  logic [thpc_pkg::CountW-1:0] pending_path_counts[$];
  int unsigned dp_paths [0:TableDepth-1][0:thpc_pkg::MaxVert-1];

  int error_count = 0;
  int quiet_cycles = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int rx_hold_cycles = 0;
  int rx_stall_left = 0;

  tournament_hamiltonian_path_count_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Count Hamiltonian paths with the subset-by-endpoint table.
  function automatic logic [thpc_pkg::CountW-1:0] count_hamiltonian_paths(
      input logic [thpc_pkg::NumW-1:0] setting, input logic [thpc_pkg::ArcW-1:0] arcs);
    logic [thpc_pkg::MaxVert-1:0] beats [0:thpc_pkg::MaxVert-1];
    int n, i, j, v, w, p, full, mask;
    int unsigned c, total;
    n = (setting > thpc_pkg::MaxVert) ? thpc_pkg::MaxVert : int'(setting);
    if (n == 0) begin
      return '0;
    end
    for (i = 0; i < thpc_pkg::MaxVert; i++) begin
      beats[i] = '0;
    end
    p = 0;
    for (i = 0; i < n; i++) begin
      for (j = i + 1; j < n; j++) begin
        if (arcs[p]) begin
          beats[i][j] = 1'b1;
        end else begin
          beats[j][i] = 1'b1;
        end
        p++;
      end
    end
    full = (1 << n) - 1;
    for (mask = 0; mask <= full; mask++) begin
      for (v = 0; v < n; v++) begin
        dp_paths[mask][v] = 0;
      end
    end
    for (v = 0; v < n; v++) begin
      dp_paths[1 << v][v] = 1;
    end
    for (mask = 1; mask <= full; mask++) begin
      for (v = 0; v < n; v++) begin
        if (mask[v] && dp_paths[mask][v] != 0) begin
          c = dp_paths[mask][v];
          for (w = 0; w < n; w++) begin
            if (!mask[w] && beats[v][w]) begin
              dp_paths[mask | (1 << w)][w] += c;
            end
          end
        end
      end
    end
    total = 0;
    for (v = 0; v < n; v++) begin
      total += dp_paths[full][v];
    end
    return total[thpc_pkg::CountW-1:0];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [thpc_pkg::ArcW-1:0] random_orientation();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[thpc_pkg::ArcW-1:0];
  endfunction

  // Odd n: vertex i beats the next (n-1)/2 vertices around the circle.
  function automatic logic [thpc_pkg::ArcW-1:0] rotational_tournament(input int n);
    logic [thpc_pkg::ArcW-1:0] arcs;
    int i, j, p;
    arcs = '0;
    p = 0;
    for (i = 0; i < n; i++) begin
      for (j = i + 1; j < n; j++) begin
        if (j - i <= (n - 1) / 2) begin
          arcs[p] = 1'b1;
        end
        p++;
      end
    end
    return arcs;
  endfunction

  // Offer one word; record its expected count once it is taken.
  task automatic send_orientation(input logic [thpc_pkg::ArcW-1:0] arcs);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(thpc_pkg::InDataW - thpc_pkg::ArcW){1'b0}}, arcs};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_path_counts.push_back(count_hamiltonian_paths(vertex_count_setting, arcs));
  endtask

  // Drop valid and wait until every expected count has come back.
  task automatic await_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_path_counts.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_vertex_count(input logic [thpc_pkg::NumW-1:0] value);
    await_results();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    vertex_count_setting = value;
  endtask

  // Reset setting of nine vertices, without any register write.
  task automatic test_reset_setting();
    send_orientation('0);
    send_orientation('1);
    send_orientation(rotational_tournament(9));
    send_orientation(random_orientation());
  endtask

  // Zero, one, two and three vertices, unused bits set.
  task automatic test_tiny_sizes();
    set_vertex_count(4'd0);
    send_orientation('1);
    send_orientation('0);
    set_vertex_count(4'd1);
    send_orientation('1);
    set_vertex_count(4'd2);
    send_orientation('0);
    send_orientation({{(thpc_pkg::ArcW - 1){1'b0}}, 1'b1});
    send_orientation({{(thpc_pkg::ArcW - 1){1'b1}}, 1'b0});
    set_vertex_count(4'd3);
    send_orientation(55'b101);    // cyclic triangle
    send_orientation(55'b010);    // the other cyclic triangle
    send_orientation(55'b111);    // transitive
  endtask

  // Full size, and settings above the maximum that saturate to it.
  task automatic test_largest_sizes();
    set_vertex_count(4'd11);
    send_orientation(rotational_tournament(11));
    send_orientation('0);
    set_vertex_count(4'd10);
    send_orientation(random_orientation());
    set_vertex_count(4'd15);
    send_orientation(random_orientation());
    set_vertex_count(4'd12);
    send_orientation(rotational_tournament(11));
  endtask

  // Hold the receiver off so the block fills and stalls its input.
  task automatic test_backpressure();
    int k;
    set_vertex_count(4'd4);
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 600;
    for (k = 0; k < 6; k++) begin
      send_orientation(random_orientation());
    end
    tx_gaps_on = 1'b1;
  endtask

  // Random phases, mostly small sizes, a few large ones with few words.
  task automatic test_random_tournaments();
    int phase, k, count;
    logic [thpc_pkg::NumW-1:0] size;
    for (phase = 0; phase < 10; phase++) begin
      if ($urandom_range(0, 4) == 0) begin
        size = thpc_pkg::NumW'($urandom_range(0, 15));
      end else begin
        size = thpc_pkg::NumW'($urandom_range(2, 8));
      end
      set_vertex_count(size);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      count = (size > 8) ? $urandom_range(1, 2) : $urandom_range(6, 10);
      if (phase == 0) begin
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
      end
      for (k = 0; k < count; k++) begin
        send_orientation(random_orientation());
      end
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Receiver: long hold-off when asked, else random stalls.
  always @(negedge clk_i) begin
    logic ready_next;
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      ready_next = 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
      if (rx_stalls_on) begin
        rx_stall_left = pick_gap();
      end
    end
    m_axis_tready <= ready_next;
  end

  // Compare each returned count with the oldest expectation.
  always @(posedge clk_i) begin
    logic [thpc_pkg::CountW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_path_counts.size() == 0) begin
        $display("%0t: unexpected word, path_count expected none, got %0d",
                 $time, m_axis_tdata[thpc_pkg::CountW-1:0]);
        error_count++;
      end else begin
        want = pending_path_counts.pop_front();
        if (m_axis_tdata[thpc_pkg::CountW-1:0] !== want) begin
          $display("%0t: path_count mismatch, expected %0d, got %0d",
                   $time, want, m_axis_tdata[thpc_pkg::CountW-1:0]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_setting();
    test_tiny_sizes();
    test_largest_sizes();
    test_backpressure();
    test_random_tournaments();
    await_results();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && pending_path_counts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
